// ===== hw/rtl/mpded_pkg.sv =====
// Package with the pin status codes, edge codes and the per-pin update function.
`timescale 1ns / 1ps
package mpded_pkg;

	localparam int NUM_PINS = 8;
	localparam int PIN_W = 3;
	localparam int MASK_W = 8;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [MASK_W-1:0] DEBOUNCE_MASK_RST = 8'd15;
	localparam logic [MASK_W-1:0] FALL_SUPP_MASK_RST = 8'd7;

	typedef enum logic [0:0] {
		REG_DEBOUNCE_MASK = 1'b0,
		REG_FALL_SUPP_MASK = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		ST_REL = 4'd0,
		ST_REL1 = 4'd1,
		ST_REL2 = 4'd2,
		ST_BREL = 4'd3,
		ST_BREL1 = 4'd4,
		ST_PRS = 4'd5,
		ST_PRS1 = 4'd6,
		ST_PRS2 = 4'd7,
		ST_BPRS = 4'd8,
		ST_BPRS1 = 4'd9,
		ST_UNSTABLE = 4'd10
	} pin_state_t;

	typedef enum logic [1:0] {
		EV_NONE = 2'd0,
		EV_RISE = 2'd1,
		EV_FALL = 2'd2
	} edge_t;

	typedef struct packed {
		pin_state_t nx;
		edge_t ev;
	} pin_upd_t;

	// Next status and edge for one sample of one pin.
	function automatic pin_upd_t pin_update(pin_state_t st, logic high, logic deb,
			logic supp);
		pin_upd_t r;
		r.nx = st;
		r.ev = EV_NONE;
		if (deb) begin
			case (st)
				ST_REL: begin
					if (high) r.nx = ST_REL1;
				end
				ST_REL1: r.nx = high ? ST_REL2 : ST_BREL;
				ST_BREL: r.nx = high ? ST_BREL1 : ST_UNSTABLE;
				ST_REL2, ST_BREL1: begin
					if (high) begin
						r.nx = ST_PRS;
						r.ev = EV_RISE;
					end else begin
						r.nx = ST_UNSTABLE;
					end
				end
				ST_PRS: begin
					if (!high) r.nx = ST_PRS1;
				end
				ST_PRS1: r.nx = !high ? ST_PRS2 : ST_BPRS;
				ST_BPRS: r.nx = !high ? ST_BPRS1 : ST_UNSTABLE;
				ST_PRS2, ST_BPRS1: begin
					if (!high) begin
						r.nx = ST_REL;
						r.ev = EV_FALL;
					end else begin
						r.nx = ST_UNSTABLE;
					end
				end
				default: r.nx = st;
			endcase
		end else begin
			if (st == ST_REL && high) begin
				r.nx = ST_PRS;
				r.ev = EV_RISE;
			end else if (st == ST_PRS && !high) begin
				r.nx = ST_REL;
				r.ev = EV_FALL;
			end
		end
		// The level still changes when a falling event is suppressed.
		if (r.ev == EV_FALL && supp) r.ev = EV_NONE;
		return r;
	endfunction

endpackage

// ===== hw/rtl/multi_pin_debounce_edge_detector.sv =====
// Multi-pin debouncer and edge detector: input stage, status update and result register.
// An accepted sample waits in the input stage and moves to the result register, which drives
// the outputs, whenever the result register is free or being drained.
// Throughput: one sample per cycle unless the result stalls, also for repeated samples of
// one pin, as its status is read and rewritten in the same cycle that moves it to the result.
// Reset: arst_n clears all pin states to released, empties both stages and loads the masks
// with their reset values (debounce 15, falling suppress 7).
`timescale 1ns / 1ps
module multi_pin_debounce_edge_detector
	import mpded_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [PIN_W-1:0] pin_index,
	input logic sample_level,
	output logic out_valid,
	input logic out_ready,
	output logic [PIN_W-1:0] event_pin,
	output logic [1:0] edge_event,
	output logic pin_unstable,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [PADDR_W-1:0] paddr,
	input logic [PDATA_W-1:0] pwdata,
	output logic [PDATA_W-1:0] prdata,
	output logic pready
);

	logic [MASK_W-1:0] debounce_mask_q;
	logic [MASK_W-1:0] fall_supp_mask_q;
	pin_state_t status_q [NUM_PINS];

	logic valid_s1;
	logic [PIN_W-1:0] pin_s1;
	logic level_s1;

	logic [PIN_W-1:0] event_pin_q;
	edge_t edge_q;
	logic unstable_q;

	logic advance;
	logic in_range;
	pin_upd_t upd;
	reg_idx_t reg_idx;

	assign pready = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[2]);

	always_comb begin
		case (reg_idx)
			REG_DEBOUNCE_MASK: prdata = PDATA_W'(debounce_mask_q);
			REG_FALL_SUPP_MASK: prdata = PDATA_W'(fall_supp_mask_q);
			default: prdata = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_mask_q <= DEBOUNCE_MASK_RST;
			fall_supp_mask_q <= FALL_SUPP_MASK_RST;
		end else if (psel && penable && pwrite) begin
			case (reg_idx)
				REG_DEBOUNCE_MASK: debounce_mask_q <= pwdata[MASK_W-1:0];
				REG_FALL_SUPP_MASK: fall_supp_mask_q <= pwdata[MASK_W-1:0];
				default: ;
			endcase
		end
	end

	// The staged sample moves on whenever the result register is empty or being drained.
	assign advance = valid_s1 && (!out_valid || out_ready);
	assign in_ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			pin_s1 <= pin_index;
			level_s1 <= sample_level;
		end
	end

	assign in_range = (32'(pin_s1) < 32'(NUM_PINS));

	always_comb begin
		upd.nx = ST_REL;
		upd.ev = EV_NONE;
		if (in_range) begin
			upd = pin_update(status_q[pin_s1], level_s1, debounce_mask_q[pin_s1],
				fall_supp_mask_q[pin_s1]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_PINS; i++) begin
				status_q[i] <= ST_REL;
			end
		end else if (advance && in_range) begin
			status_q[pin_s1] <= upd.nx;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			event_pin_q <= pin_s1;
			edge_q <= upd.ev;
			unstable_q <= in_range && (upd.nx == ST_UNSTABLE);
		end
	end

	assign event_pin = event_pin_q;
	assign edge_event = edge_q;
	assign pin_unstable = unstable_q;

	// A pin locked unstable never reports an edge.
	a_unstable_no_edge: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && pin_unstable |-> edge_event == EV_NONE)
		else $error("unstable pin reported an edge");

	// A rising result leaves its pin in the pressed state.
	a_rise_pressed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_event == EV_RISE |-> status_q[event_pin] == ST_PRS)
		else $error("rising edge without pressed status");

	// A falling result leaves its pin in the released state.
	a_fall_released: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && edge_event == EV_FALL |-> status_q[event_pin] == ST_REL)
		else $error("falling edge without released status");

	// A stalled result register holds the staged sample back.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready && valid_s1 |-> !in_ready)
		else $error("input taken while both stages are blocked");

endmodule
